[rtl/mrbp_pkg.sv]
// types and constants shared by the move record bit packer
// depends on nothing; imported by mrbp_pack and move_record_bit_packer
`default_nettype none

package mrbp_pkg;

    // item kinds
    typedef enum logic [1:0] {
        KIND_MOVE      = 2'd0,
        KIND_SEPARATOR = 2'd1,
        KIND_SURRENDER = 2'd2,
        KIND_FLUSH     = 2'd3
    } t_kind;

    localparam int unsigned REC_BITS = 19;
    localparam int unsigned WIN_BITS = 32;

    // input item, one transfer on the input channel
    typedef struct packed {
        t_kind       kind;
        logic [6:0]  pos_x;
        logic [6:0]  pos_y;
        logic [4:0]  player;
        logic [1:0]  direction;
        logic        half_flag;
    } t_in_item;

    // result item, one transfer on the output channel
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
    } t_out_item;

    // outcome of packing one item against the accumulator
    typedef struct packed {
        logic [23:0] bytes;         // first byte in the top bits
        logic [1:0]  count;         // bytes given out, 0 to 3
        logic [7:0]  next_pending;
        logic [2:0]  next_bit_pos;
    } t_pack_res;

endpackage : mrbp_pkg

`default_nettype wire

[rtl/mrbp_pack.sv]
// record formation and byte alignment for one item
// depends on mrbp_pkg
`default_nettype none

module mrbp_pack
    import mrbp_pkg::*;
(
    input  var t_in_item   i_item,
    input  var logic [7:0] i_pending,
    input  var logic [2:0] i_bit_pos,
    output t_pack_res      o_res
);

    logic [5:0]          x6;
    logic [5:0]          y6;
    logic [3:0]          p4;
    logic [REC_BITS-1:0] rec;
    logic [WIN_BITS-1:0] win;
    logic [4:0]          shamt;
    logic                three_bytes;

    // coordinates and player stored minus one, wrapping
    assign x6 = i_item.pos_x[5:0] - 6'd1;
    assign y6 = i_item.pos_y[5:0] - 6'd1;
    assign p4 = i_item.player[3:0] - 4'd1;

    // record layout per kind
    always_comb begin
        case (i_item.kind)
            KIND_MOVE:      rec = {x6, y6, p4, i_item.direction, i_item.half_flag};
            KIND_SEPARATOR: rec = {REC_BITS{1'b1}};
            KIND_SURRENDER: rec = {12'hFFF, p4, 3'b000};
            default:        rec = '0;
        endcase
    end

    // line the record up behind the pending bits, msb first
    assign shamt = 5'd13 - {2'b00, i_bit_pos};
    assign win   = {i_pending, 24'h0} | ({13'h0, rec} << shamt);

    // three bytes once the pending bits reach five or more
    assign three_bytes = i_bit_pos[2] & (i_bit_pos[1] | i_bit_pos[0]);

    always_comb begin
        if (i_item.kind == KIND_FLUSH) begin
            o_res.bytes        = {i_pending, 16'h0};
            o_res.count        = (i_bit_pos != 3'd0) ? 2'd1 : 2'd0;
            o_res.next_pending = 8'h00;
            o_res.next_bit_pos = 3'd0;
        end else begin
            o_res.bytes        = win[31:8];
            o_res.count        = three_bytes ? 2'd3 : 2'd2;
            o_res.next_pending = three_bytes ? win[7:0] : win[15:8];
            o_res.next_bit_pos = i_bit_pos + 3'd3;
        end
    end

endmodule : mrbp_pack

`default_nettype wire

[rtl/move_record_bit_packer.sv]
// top level of the move record bit packer: input register, packer, byte buffer
// depends on mrbp_pkg and mrbp_pack
//
// usage
//   input channel: i_in_valid / o_in_ready carry one t_in_item per transfer
//   (move, round separator, surrender or flush). output channel:
//   o_out_valid / i_out_ready carry one t_out_item per transfer, a packed
//   byte with its first bit in the msb and last set on the final byte of
//   the item. an item gives 0 to 3 bytes; a flush with nothing pending
//   gives none.
//   the first byte of an item is offered once the item has passed the input
//   register and been loaded into the byte buffer. throughput: one byte per
//   cycle on the output port while the receiver is ready, a record giving two
//   or three bytes by its byte count and a flush at most one (the output port
//   is the limit); the input register takes the next item while bytes drain.
//   reset (i_rst_n low, synchronous) empties the input register and the
//   byte buffer and clears the accumulator and bit position.
//   when the receiver stalls, the current byte holds; the buffer stays full,
//   the input register fills and then o_in_ready drops.
`default_nettype none

module move_record_bit_packer
    import mrbp_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_in_valid,
    output logic          o_in_ready,
    input  var t_in_item  i_in_item,
    output logic          o_out_valid,
    input  var logic      i_out_ready,
    output t_out_item     o_out_item
);

    t_in_item    r_in;
    logic        r_in_valid;
    logic [7:0]  r_pending;
    logic [2:0]  r_bit_pos;
    logic [23:0] r_buf;
    logic [1:0]  r_left;

    t_pack_res   w_res;
    logic        w_out_xfer;
    logic        w_buf_free;
    logic        w_load;

    // handshake terms
    assign w_out_xfer = o_out_valid && i_out_ready;
    assign w_buf_free = (r_left == 2'd0) || ((r_left == 2'd1) && w_out_xfer);
    assign w_load     = r_in_valid && w_buf_free;
    assign o_in_ready = !r_in_valid || w_buf_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // record packing
    mrbp_pack u_pack (
        .i_item    (r_in),
        .i_pending (r_pending),
        .i_bit_pos (r_bit_pos),
        .o_res     (w_res)
    );

    // accumulator state moves on when the item enters the buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 8'h00;
            r_bit_pos <= 3'd0;
        end else if (w_load) begin
            r_pending <= w_res.next_pending;
            r_bit_pos <= w_res.next_bit_pos;
        end
    end

    // byte buffer, drained one byte per transfer from the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (w_load) begin
            r_left <= w_res.count;
        end else if (w_out_xfer) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf <= w_res.bytes;
        end else if (w_out_xfer) begin
            r_buf <= {r_buf[15:0], 8'h00};
        end
    end

    // output port
    assign o_out_valid         = (r_left != 2'd0);
    assign o_out_item.out_byte = r_buf[23:16];
    assign o_out_item.last     = (r_left == 2'd1);

    // checks
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_aligned_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_pos == 3'd0) |-> (r_pending == 8'h00))
        else $error("pending bits left on a byte boundary");

    a_bit_pos_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_in.kind != KIND_FLUSH)) |=>
            (r_bit_pos == $past(r_bit_pos) + 3'd3))
        else $error("bit position did not advance by a record");

    a_flush_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_in.kind == KIND_FLUSH)) |=>
            ((r_bit_pos == 3'd0) && (r_pending == 8'h00)))
        else $error("flush left the accumulator dirty");

endmodule : move_record_bit_packer

`default_nettype wire
